FILE: hw/rtl/small_matrix_multiply_defines.svh
// Assertion macros shared by the RTL. Each use sits on a line of its own.
// SMM_ASSERT_IMPL: same-cycle implication. SMM_ASSERT_NEXT: next-cycle implication.
// Both sample on clk and are disabled while rst_n is low.
`ifndef SMALL_MATRIX_MULTIPLY_DEFINES_SVH
`define SMALL_MATRIX_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS

`define SMM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smm assertion failed");

`define SMM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smm assertion failed");

`else

`define SMM_ASSERT_IMPL(name, ante, cons)

`define SMM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: hw/rtl/smm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smm_pkg;

    // default matrix geometry
    localparam int MAX_ROWS_DEF  = 4;
    localparam int INNER_DIM_DEF = 4;
    localparam int OUT_COLS_DEF  = 4;

    // command queue between front end and engine
    localparam int QUEUE_DEPTH = 4;

    localparam int VALUE_W = 32;
    localparam int IDX_W   = 2;
    localparam int MODE_W  = 2;
    localparam int ROWS_W  = 3;
    localparam int FRAC_W  = 16;

    localparam logic [ROWS_W-1:0] ACTIVE_ROWS_RST = 3'd4;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // stream packing: row, col, value from the low bit up, padded to bytes
    localparam int FIELDS_W    = 2 * IDX_W + VALUE_W;
    localparam int TDATA_W     = ((FIELDS_W + 7) / 8) * 8;
    localparam int TDATA_PAD_W = TDATA_W - FIELDS_W;
    localparam int COL_LSB     = IDX_W;
    localparam int VALUE_LSB   = 2 * IDX_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A  = 2'd0,
        MODE_LOAD_B  = 2'd1,
        MODE_COMPUTE = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                     kind;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    // one result element, engine to output stage
    typedef struct packed {
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      sat;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/small_matrix_multiply.sv
`timescale 1ns / 1ps
`default_nettype none
// Small dense matrix multiply, C = A x B, signed Q16.16. Each request on the
// input stream is a load of one A element (tuser = 0), a load of one B element
// (tuser = 1) or a compute (tuser = 2); tuser = 3 and loads outside the stored
// arrays are dropped at the front end. A compute streams out every element of
// C for the active rows in row-major order, tlast on the final one and tuser
// high when the element was clipped. Each element is the exact sum of the
// 64-bit products, floored by 2^16 and saturated to 32 bits. A front end
// checks and registers requests, a four-entry command queue decouples it from
// the engine, so up to five requests (queue plus front register) are absorbed
// while a compute runs before the input stalls. Loads retire at one per
// cycle while no compute is running. Each element of C is paced by the
// single shared 32x32 multiplier and the one read port of each matrix
// store: INNER_DIM reads are issued, then the read, multiply and
// accumulate registers drain, then the element is handed to the output
// register. A compute holds the engine until its last element is handed on.
// Reading an element of A or B that was never loaded returns an undefined
// value. The user must write active_rows (reset 4) on the cfg channel only
// while the block is idle; the block itself does not enforce this. 0 acts
// as 1 and values above MAX_ROWS act as MAX_ROWS.

module small_matrix_multiply #(
    parameter int MAX_ROWS  = smm_pkg::MAX_ROWS_DEF,
    parameter int INNER_DIM = smm_pkg::INNER_DIM_DEF,
    parameter int OUT_COLS  = smm_pkg::OUT_COLS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [1:0] row_index, [3:2] col_index, [35:4] element_value, [39:36] zero
    input  wire logic [smm_pkg::TDATA_W-1:0]   s_axis_tdata,
    // [1:0] mode
    input  wire logic [smm_pkg::MODE_W-1:0]    s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [1:0] out_row, [3:2] out_col, [35:4] out_value, [39:36] zero
    output logic [smm_pkg::TDATA_W-1:0]        m_axis_tdata,
    output logic                               m_axis_tlast,
    // [0] saturated
    output logic                               m_axis_tuser,
    // active_rows write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [smm_pkg::ROWS_W-1:0]    cfg_data
);
    import smm_pkg::*;

    logic [ROWS_W-1:0] active_rows_reg;

    logic    fe_valid;
    logic    fe_ready;
    cmd_t    fe_cmd;
    logic    q_valid;
    logic    q_ready;
    cmd_t    q_cmd;
    result_t res;

    // config register; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_rows_reg <= ACTIVE_ROWS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_rows_reg <= cfg_data;
        end
    end

    // front end: unpack, filter, register
    smm_front #(
        .MAX_ROWS  (MAX_ROWS),
        .INNER_DIM (INNER_DIM),
        .OUT_COLS  (OUT_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_row    (s_axis_tdata[IDX_W-1:0]),
        .in_col    (s_axis_tdata[COL_LSB+IDX_W-1:COL_LSB]),
        .in_value  (s_axis_tdata[VALUE_LSB+VALUE_W-1:VALUE_LSB]),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_cmd   (fe_cmd)
    );

    // command queue
    smm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_cmd   (fe_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // back end: matrix stores, MAC pipeline, output register
    smm_engine #(
        .MAX_ROWS  (MAX_ROWS),
        .INNER_DIM (INNER_DIM),
        .OUT_COLS  (OUT_COLS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .cmd         (q_cmd),
        .active_rows (active_rows_reg),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res         (res)
    );

    assign m_axis_tdata = {{TDATA_PAD_W{1'b0}}, res.value, res.col, res.row};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.sat;

endmodule

`default_nettype wire

FILE: hw/rtl/smm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module smm_front #(
    parameter int MAX_ROWS  = 4,
    parameter int INNER_DIM = 4,
    parameter int OUT_COLS  = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [smm_pkg::MODE_W-1:0]        in_mode,
    input  wire logic [smm_pkg::IDX_W-1:0]         in_row,
    input  wire logic [smm_pkg::IDX_W-1:0]         in_col,
    input  wire logic signed [smm_pkg::VALUE_W-1:0] in_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output smm_pkg::cmd_t                          out_cmd
);
    import smm_pkg::*;

    logic keep;
    cmd_t cmd_reg;
    logic cmd_valid_reg;

    // drop unused modes and out-of-range loads here
    always_comb
    begin
        case (mode_t'(in_mode))
            MODE_LOAD_A:  keep = (int'(in_row) < MAX_ROWS) && (int'(in_col) < INNER_DIM);
            MODE_LOAD_B:  keep = (int'(in_row) < INNER_DIM) && (int'(in_col) < OUT_COLS);
            MODE_COMPUTE: keep = 1'b1;
            default:      keep = 1'b0;
        endcase
    end

    assign in_ready  = !cmd_valid_reg || out_ready;
    assign out_valid = cmd_valid_reg;
    assign out_cmd   = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            cmd_valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg.kind  <= mode_t'(in_mode);
            cmd_reg.row   <= in_row;
            cmd_reg.col   <= in_col;
            cmd_reg.value <= in_value;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/smm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "small_matrix_multiply_defines.svh"

module smm_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire smm_pkg::cmd_t push_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output smm_pkg::cmd_t      pop_cmd
);
    import smm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             q_mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = q_mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `SMM_ASSERT_IMPL(a_q_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SMM_ASSERT_NEXT(a_q_push_grows, do_push && !do_pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

FILE: hw/rtl/smm_engine.sv
`timescale 1ns / 1ps
`default_nettype none
`include "small_matrix_multiply_defines.svh"

module smm_engine #(
    parameter int MAX_ROWS  = 4,
    parameter int INNER_DIM = 4,
    parameter int OUT_COLS  = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire smm_pkg::cmd_t              cmd,
    input  wire logic [smm_pkg::ROWS_W-1:0] active_rows,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output smm_pkg::result_t                res
);
    import smm_pkg::*;

    localparam int LEFT_DEPTH  = MAX_ROWS * INNER_DIM;
    localparam int RIGHT_DEPTH = INNER_DIM * OUT_COLS;
    localparam int LA_W  = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
    localparam int RA_W  = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
    localparam int R_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int K_W   = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;
    localparam int C_W   = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int ACC_W  = PROD_W + $clog2(INNER_DIM) + 1;
    localparam int SUM_W  = ACC_W - FRAC_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic [R_W-1:0] r_reg;
    logic [C_W-1:0] c_reg;
    logic [K_W-1:0] k_reg;
    logic [R_W-1:0] last_row_reg;
    logic [R_W-1:0] last_row;

    logic [VALUE_W-1:0] left_mem  [LEFT_DEPTH];
    logic [VALUE_W-1:0] right_mem [RIGHT_DEPTH];
    logic [LA_W-1:0] left_wa;
    logic [RA_W-1:0] right_wa;
    logic [LA_W-1:0] left_ra;
    logic [RA_W-1:0] right_ra;

    logic                       rd_v_reg;
    logic                       rd_first_reg;
    logic                       rd_last_reg;
    logic signed [VALUE_W-1:0]  a_rd_reg;
    logic signed [VALUE_W-1:0]  b_rd_reg;
    logic                       prod_v_reg;
    logic                       prod_first_reg;
    logic                       prod_last_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    prod_ext;
    logic                       acc_done_reg;

    logic                       issue;
    logic                       k_last;
    logic                       c_last;
    logic                       elem_last;
    logic                       slot_free;
    logic                       take_cmd;
    logic [SUM_W-1:0]           sum_q;
    logic                       ovf_pos;
    logic                       ovf_neg;
    logic signed [VALUE_W-1:0]  sat_value;

    logic    res_valid_reg;
    result_t res_reg;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign take_cmd  = cmd_valid && cmd_ready;
    assign issue     = (state_reg == ST_RUN);
    assign k_last    = (k_reg == K_W'(INNER_DIM - 1));
    assign c_last    = (c_reg == C_W'(OUT_COLS - 1));
    assign elem_last = c_last && (r_reg == last_row_reg);
    assign slot_free = !res_valid_reg || res_ready;

    assign left_wa  = LA_W'(int'(cmd.row) * INNER_DIM + int'(cmd.col));
    assign right_wa = RA_W'(int'(cmd.row) * OUT_COLS + int'(cmd.col));
    assign left_ra  = LA_W'(int'(r_reg) * INNER_DIM + int'(k_reg));
    assign right_ra = RA_W'(int'(k_reg) * OUT_COLS + int'(c_reg));

    // zero acts as one row, anything above MAX_ROWS as MAX_ROWS
    always_comb
    begin
        if (active_rows == '0)
        begin
            last_row = '0;
        end
        else if (int'(active_rows) > MAX_ROWS)
        begin
            last_row = R_W'(MAX_ROWS - 1);
        end
        else
        begin
            last_row = R_W'(active_rows - ROWS_W'(1));
        end
    end

    // floor(sum / 2^16), then clip to 32 bits
    assign prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign sum_q     = acc_reg[ACC_W-1:FRAC_W];
    assign ovf_pos   = !sum_q[SUM_W-1] && (|sum_q[SUM_W-1:VALUE_W-1]);
    assign ovf_neg   = sum_q[SUM_W-1] && !(&sum_q[SUM_W-1:VALUE_W-1]);
    assign sat_value = ovf_pos ? VALUE_MAX : (ovf_neg ? VALUE_MIN : sum_q[VALUE_W-1:0]);

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // matrix stores, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (take_cmd && cmd.kind == MODE_LOAD_A)
        begin
            left_mem[left_wa] <= cmd.value;
        end
        if (take_cmd && cmd.kind == MODE_LOAD_B)
        begin
            right_mem[right_wa] <= cmd.value;
        end
        if (issue)
        begin
            a_rd_reg <= left_mem[left_ra];
            b_rd_reg <= right_mem[right_ra];
        end
    end

    // multiply and accumulate datapath
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= a_rd_reg * b_rd_reg;
        end
        if (prod_v_reg)
        begin
            acc_reg <= prod_first_reg ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            r_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            last_row_reg   <= '0;
            rd_v_reg       <= 1'b0;
            rd_first_reg   <= 1'b0;
            rd_last_reg    <= 1'b0;
            prod_v_reg     <= 1'b0;
            prod_first_reg <= 1'b0;
            prod_last_reg  <= 1'b0;
            acc_done_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            rd_v_reg       <= issue;
            rd_first_reg   <= issue && (k_reg == '0);
            rd_last_reg    <= issue && k_last;
            prod_v_reg     <= rd_v_reg;
            prod_first_reg <= rd_first_reg;
            prod_last_reg  <= rd_last_reg;
            acc_done_reg   <= prod_v_reg && prod_last_reg;

            // drained slot clears unless a new element is loaded this cycle
            if (res_ready && !(state_reg == ST_EMIT && slot_free))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (take_cmd && cmd.kind == MODE_COMPUTE)
                    begin
                        last_row_reg <= last_row;
                        r_reg        <= '0;
                        c_reg        <= '0;
                        k_reg        <= '0;
                        state_reg    <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (k_last)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
                ST_WAIT:
                begin
                    if (acc_done_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg.row   <= IDX_W'(r_reg);
                        res_reg.col   <= IDX_W'(c_reg);
                        res_reg.value <= sat_value;
                        res_reg.last  <= elem_last;
                        res_reg.sat   <= ovf_pos || ovf_neg;
                        if (elem_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                            if (c_last)
                            begin
                                c_reg <= '0;
                                r_reg <= r_reg + R_W'(1);
                            end
                            else
                            begin
                                c_reg <= c_reg + C_W'(1);
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `SMM_ASSERT_IMPL(a_pipe_empty_idle, state_reg == ST_IDLE, !rd_v_reg && !prod_v_reg && !acc_done_reg)
    `SMM_ASSERT_IMPL(a_row_in_range, state_reg != ST_IDLE, r_reg <= last_row_reg)
    `SMM_ASSERT_IMPL(a_done_only_waiting, acc_done_reg, state_reg == ST_WAIT)
    `SMM_ASSERT_NEXT(a_last_ends_run, state_reg == ST_EMIT && slot_free && elem_last, state_reg == ST_IDLE && res_reg.last)

endmodule

`default_nettype wire
